>>> sv/tftp_block_sender_core_defines.svh
// ----------------------------------------------------------------------------
// tftp_block_sender_core_defines
// Assertion macros used by the TFTP block sender core.
// ----------------------------------------------------------------------------
`ifndef TFTP_BLOCK_SENDER_CORE_DEFINES_SVH
`define TFTP_BLOCK_SENDER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tbs_pkg.sv
// ----------------------------------------------------------------------------
// tbs_pkg
// Types, codes and constants of the TFTP block sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbs_pkg;

    localparam int unsigned ACK_READ_LIMIT  = 10;
    localparam int unsigned MAX_BLOCK_BYTES = 65464;
    localparam int unsigned MIN_BLOCK_BYTES = 8;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b1;

    localparam logic [7:0]  RETRY_LIMIT_RST = 8'd5;
    localparam logic [15:0] BLOCK_SIZE_RST  = 16'd512;

    localparam logic [15:0] OPC_ACK       = 16'd4;
    localparam logic [15:0] BLK_REXMIT    = 16'hffff;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_CHUNK   = 2'd1,
        FUNC_PACKET  = 2'd2,
        FUNC_TIMEOUT = 2'd3
    } tbs_func_t;

    typedef enum logic [2:0] {
        ACT_WAIT  = 3'd0,
        ACT_FETCH = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_DONE  = 3'd3,
        ACT_NAK   = 3'd4,
        ACT_ABORT = 3'd5
    } tbs_action_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_OACK  = 4'b0010,
        PH_FETCH = 4'b0100,
        PH_ACK   = 4'b1000
    } tbs_phase_t;

    typedef struct packed {
        tbs_func_t   func;
        logic        options_sent;
        logic [15:0] chunk_len;
        logic        read_failed;
        logic [15:0] rx_opcode;
        logic [15:0] rx_block;
    } tbs_event_t;

    typedef struct packed {
        tbs_phase_t  phase;
        logic [15:0] block_count;
        logic [15:0] last_length;
        logic [7:0]  retransmits;
        logic [3:0]  ignored_acks;
    } tbs_state_t;

    typedef struct packed {
        tbs_action_t action;
        logic [15:0] block_number;
        logic [15:0] data_len;
    } tbs_result_t;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic [15:0] eff_block_size;
    } tbs_cfg_t;

endpackage

>>> sv/tbs_cfg.sv
// ----------------------------------------------------------------------------
// tbs_cfg
// Configuration registers; block size is stored already clamped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbs_cfg
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tbs_cfg_t              cfg
);

    logic [7:0]  retry_limit_reg;
    logic [15:0] block_size_reg;
    logic [15:0] block_size_clamped;

    always_comb
    begin
        if (cfg_data < 16'(MIN_BLOCK_BYTES))
            block_size_clamped = 16'(MIN_BLOCK_BYTES);
        else if (cfg_data > 16'(MAX_BLOCK_BYTES))
            block_size_clamped = 16'(MAX_BLOCK_BYTES);
        else
            block_size_clamped = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            block_size_reg  <= BLOCK_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RETRY_LIMIT: retry_limit_reg <= cfg_data[7:0];
                REG_BLOCK_SIZE:  block_size_reg  <= block_size_clamped;
                default: ;
            endcase
        end
    end

    assign cfg.retry_limit    = retry_limit_reg;
    assign cfg.eff_block_size = block_size_reg;

endmodule

>>> sv/tbs_fsm.sv
// ----------------------------------------------------------------------------
// tbs_fsm
// Transfer decision logic: one event and the current state in, next state
// and one result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbs_fsm
    import tbs_pkg::*;
(
    input  tbs_event_t  ev,
    input  tbs_state_t  st,
    input  tbs_cfg_t    cfg,
    output tbs_state_t  st_next,
    output tbs_result_t res
);

    logic [15:0] bc_inc;
    logic [15:0] exp_blk;
    logic [15:0] exp_blk_inc;
    logic [3:0]  ig_inc;
    logic [15:0] clen_cut;
    logic        awaiting;
    logic        rexmit;

    assign bc_inc      = st.block_count + 16'd1;
    assign exp_blk     = (st.phase == PH_OACK) ? 16'd0 : st.block_count;
    assign exp_blk_inc = exp_blk + 16'd1;
    assign ig_inc      = st.ignored_acks + 4'd1;
    assign clen_cut    = (ev.chunk_len > cfg.eff_block_size) ? cfg.eff_block_size
                                                            : ev.chunk_len;
    assign awaiting    = (st.phase == PH_OACK) || (st.phase == PH_ACK);

    always_comb
    begin
        st_next          = st;
        res.action       = ACT_WAIT;
        res.block_number = st.block_count;
        res.data_len     = '0;
        rexmit           = 1'b0;

        unique case (ev.func)
            FUNC_START:
            begin
                if (st.phase == PH_IDLE)
                begin
                    st_next.last_length  = '0;
                    st_next.retransmits  = '0;
                    st_next.ignored_acks = '0;
                    if (ev.options_sent)
                    begin
                        st_next.block_count = '0;
                        st_next.phase       = PH_OACK;
                        res.block_number    = '0;
                    end
                    else
                    begin
                        st_next.block_count = 16'd1;
                        st_next.phase       = PH_FETCH;
                        res.action          = ACT_FETCH;
                        res.block_number    = 16'd1;
                    end
                end
            end
            FUNC_CHUNK:
            begin
                if (st.phase == PH_FETCH)
                begin
                    if (ev.read_failed)
                    begin
                        st_next.phase = PH_IDLE;
                        res.action    = ACT_NAK;
                    end
                    else
                    begin
                        st_next.last_length  = clen_cut;
                        st_next.retransmits  = '0;
                        st_next.ignored_acks = '0;
                        st_next.phase        = PH_ACK;
                        res.action           = ACT_SEND;
                        res.data_len         = clen_cut;
                    end
                end
            end
            FUNC_PACKET:
            begin
                if (awaiting)
                begin
                    if (ev.rx_opcode != OPC_ACK)
                    begin
                        st_next.ignored_acks = '0;
                        st_next.phase        = PH_IDLE;
                        res.action           = ACT_ABORT;
                    end
                    else if (ev.rx_block == exp_blk || ev.rx_block == exp_blk_inc)
                    begin
                        st_next.ignored_acks = '0;
                        if (st.phase == PH_OACK)
                        begin
                            st_next.block_count = 16'd1;
                            st_next.phase       = PH_FETCH;
                            res.action          = ACT_FETCH;
                            res.block_number    = 16'd1;
                        end
                        else if (st.last_length != cfg.eff_block_size)
                        begin
                            // short block acked: transfer complete
                            st_next.phase = PH_IDLE;
                            res.action    = ACT_DONE;
                        end
                        else
                        begin
                            st_next.block_count = bc_inc;
                            st_next.phase       = PH_FETCH;
                            res.action          = ACT_FETCH;
                            res.block_number    = bc_inc;
                        end
                    end
                    else if (ev.rx_block == BLK_REXMIT)
                        rexmit = 1'b1;
                    else if (ig_inc >= 4'(ACK_READ_LIMIT))
                        rexmit = 1'b1;
                    else
                        st_next.ignored_acks = ig_inc;
                end
            end
            FUNC_TIMEOUT:
            begin
                if (awaiting)
                    rexmit = 1'b1;
            end
            default: ;
        endcase

        if (rexmit)
        begin
            st_next.ignored_acks = '0;
            // option ack never acknowledged, or retries used up
            if (st.phase == PH_OACK || st.retransmits >= cfg.retry_limit)
            begin
                st_next.phase = PH_IDLE;
                res.action    = ACT_ABORT;
            end
            else
            begin
                st_next.retransmits = st.retransmits + 8'd1;
                res.action          = ACT_SEND;
                res.data_len        = st.last_length;
            end
        end
    end

endmodule

>>> sv/tftp_block_sender_core.sv
// ----------------------------------------------------------------------------
// tftp_block_sender_core
// Sender side of a TFTP read transfer, one event word in, one result word out.
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the s_ channel (kind in s_tuser, fields in s_tdata).
//   Every event yields exactly one result word on the m_ channel, action in
//   m_tuser and block number / payload length in m_tdata.
//   An accepted event is held in an input register; the decision logic sits
//   between it and the output register, so a result word is presented once
//   registered there, and leaves at the next edge when m_tready is high.
//   One event per cycle while m_tready is high; transfer state updates as the
//   event moves into the output register, so the next event sees it at once.
//   When the receiver stalls, the output word holds and the input register
//   still takes one more word; after that s_tready drops until m_tready rises.
//   Reset empties both registers, puts the transfer in idle with all counters
//   cleared, retry limit 5 and block size 512. cfg_ writes take effect on the
//   next cycle and are meant for times when no event is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "tftp_block_sender_core_defines.svh"

module tftp_block_sender_core
    import tbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // options_sent[0], chunk_len[16:1], read_failed[17], rx_opcode[33:18],
    // rx_block[49:34], zero fill [55:50]
    input  logic [55:0]           s_tdata,
    // func[1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // block_number[15:0], data_len[31:16]
    output logic [31:0]           m_tdata,
    // action[2:0]
    output logic [2:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tbs_cfg_t    cfg;
    tbs_event_t  ev_in;
    tbs_event_t  ev_reg;
    logic        in_valid_reg;
    tbs_state_t  st_reg;
    tbs_state_t  st_next;
    tbs_result_t res_next;
    tbs_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;

    assign ev_in.func         = tbs_func_t'(s_tuser);
    assign ev_in.options_sent = s_tdata[0];
    assign ev_in.chunk_len    = s_tdata[16:1];
    assign ev_in.read_failed  = s_tdata[17];
    assign ev_in.rx_opcode    = s_tdata[33:18];
    assign ev_in.rx_block     = s_tdata[49:34];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    tbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbs_fsm u_fsm (
        .ev      (ev_reg),
        .st      (st_reg),
        .cfg     (cfg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{phase: PH_IDLE, default: '0};
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            ev_reg <= ev_in;
        if (advance)
            out_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {out_reg.data_len, out_reg.block_number};

    `TBS_ASSERT_NOW(a_ready_when_out_empty, !out_valid_reg, s_tready,
        "input not ready while output register is empty")
    `TBS_ASSERT_NOW(a_len_only_on_send, m_tvalid && m_tuser != ACT_SEND,
        m_tdata[31:16] == 16'd0, "nonzero length on a result other than send")
    `TBS_ASSERT_NOW(a_len_in_block, m_tvalid, m_tdata[31:16] <= 16'(MAX_BLOCK_BYTES),
        "payload length above maximum block size")
    `TBS_ASSERT_NEXT(a_start_busy_waits,
        advance && ev_reg.func == FUNC_START && st_reg.phase != PH_IDLE,
        m_tvalid && m_tuser == ACT_WAIT && $stable(st_reg),
        "start during a transfer did not give wait")

endmodule
